/* hdl/thread_ready_queue_sorted_insert_core_macros.svh */
// Assertion macros for the thread ready queue core checker.
// No dependencies; expects clk and rst to be visible where a macro is used.
`ifndef THREAD_READY_QUEUE_SORTED_INSERT_CORE_MACROS_SVH
`define THREAD_READY_QUEUE_SORTED_INSERT_CORE_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define TRQSI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trqsi: same-cycle check failed");

// Check a consequence in the cycle after its trigger.
`define TRQSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trqsi: next-cycle check failed");

`endif

/* hdl/trqsi_pkg.sv */
// Shared types and constants for the thread ready queue core.
// No dependencies; imported by every module of the block but trqsi_ram.
package trqsi_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        handle_in;
    logic signed [31:0] key_in;
  } cmd_t;

  typedef struct packed {
    logic [31:0]            handle_out;
    logic                   handle_valid;
    logic                   insert_refused;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   queue_empty;
  } result_t;

  typedef struct packed {
    logic [31:0]        handle;
    logic signed [31:0] key;
  } entry_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_PREV,
    RD_TAIL
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_TAIL,
    WR_FRONT,
    WR_SHIFT,
    WR_POS
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_PLAIN,
    RES_REFUSE,
    RES_POP
  } res_sel_t;

  typedef struct packed {
    logic     latch;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     pos_load;
    res_sel_t res_sel;
  } dp_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic count_one;
    logic key_below_head;
    logic entry_not_less;
    logic scan_last;
    logic at_pos;
  } dp_stat_t;

endpackage

/* hdl/trqsi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trqsi_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/trqsi_dp.sv */
// Datapath of the thread ready queue: circular slot RAM, head and count,
// walk index, latched beat and result register. Depends on trqsi_pkg, trqsi_ram.
module trqsi_dp import trqsi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cmd_t     cmd,
  input  dp_ctrl_t ctrl,
  output dp_stat_t stat,
  output result_t  result
);

  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   head_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   pos;
  logic [31:0]        handle_r;
  logic signed [31:0] key_r;
  logic [31:0]        res_handle;
  logic               res_valid;
  logic               res_refused;

  logic [IDX_W-1:0]          head_dec;
  logic [IDX_W-1:0]          head_inc;
  logic [IDX_W-1:0]          rd_log;
  logic [IDX_W-1:0]          raddr;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  entry_t                    wdata;
  entry_t                    new_entry;
  entry_t                    rdata;
  logic [$bits(entry_t)-1:0] ram_rdata;

  // Logical slot to physical address, wrapping once past the end.
  function automatic logic [IDX_W-1:0] phys_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign head_dec  = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
  assign head_inc  = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign new_entry = '{handle: handle_r, key: key_r};
  assign rdata     = entry_t'(ram_rdata);

  always_comb begin
    case (ctrl.rd_sel)
      RD_HEAD: rd_log = '0;
      RD_NEXT: rd_log = idx + IDX_W'(1);
      RD_PREV: rd_log = idx - IDX_W'(1);
      RD_TAIL: rd_log = IDX_W'(count - CNT_W'(1));
      default: rd_log = '0;
    endcase
  end

  assign raddr = phys_of(head, rd_log);

  always_comb begin
    we         = 1'b0;
    waddr      = '0;
    wdata      = new_entry;
    head_next  = head;
    count_next = count;
    case (ctrl.wr_sel)
      WR_TAIL: begin
        we         = 1'b1;
        waddr      = phys_of(head, IDX_W'(count));
        count_next = count + CNT_W'(1);
      end
      WR_FRONT: begin
        we         = 1'b1;
        waddr      = head_dec;
        head_next  = head_dec;
        count_next = count + CNT_W'(1);
      end
      WR_SHIFT: begin
        we    = 1'b1;
        waddr = phys_of(head, idx + IDX_W'(1));
        wdata = rdata;
      end
      WR_POS: begin
        we         = 1'b1;
        waddr      = phys_of(head, pos);
        count_next = count + CNT_W'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
    if (ctrl.res_sel == RES_POP) begin
      head_next  = head_inc;
      count_next = count - CNT_W'(1);
    end
  end

  trqsi_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= rd_log;
    if (ctrl.latch) begin
      handle_r <= cmd.handle_in;
      key_r    <= cmd.key_in;
    end
    if (ctrl.pos_load) begin
      pos <= idx;
    end
    case (ctrl.res_sel)
      RES_PLAIN: begin
        res_handle  <= '0;
        res_valid   <= 1'b0;
        res_refused <= 1'b0;
      end
      RES_REFUSE: begin
        res_handle  <= '0;
        res_valid   <= 1'b0;
        res_refused <= 1'b1;
      end
      RES_POP: begin
        res_handle  <= rdata.handle;
        res_valid   <= 1'b1;
        res_refused <= 1'b0;
      end
      default: begin
        res_handle <= res_handle;
      end
    endcase
  end

  assign stat.full           = (count == CNT_W'(DEPTH));
  assign stat.empty          = (count == '0);
  assign stat.count_one      = (count == CNT_W'(1));
  assign stat.key_below_head = (key_r < rdata.key);
  assign stat.entry_not_less = (rdata.key >= key_r);
  assign stat.scan_last      = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign stat.at_pos         = (idx == pos);

  assign result.handle_out     = res_handle;
  assign result.handle_valid   = res_valid;
  assign result.insert_refused = res_refused;
  assign result.entry_count    = COUNT_OUT_W'(count);
  assign result.queue_empty    = stat.empty;

endmodule

/* hdl/trqsi_ctrl.sv */
// Controller of the thread ready queue: sequences accept, decision, scan,
// shift and place steps. Depends on trqsi_pkg.
module trqsi_ctrl import trqsi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func_in,
  input  dp_stat_t   stat,
  output dp_ctrl_t   ctrl,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_PLACE
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] func;
  logic       finish;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctrl.latch    = 1'b0;
    ctrl.rd_sel   = RD_HEAD;
    ctrl.wr_sel   = WR_NONE;
    ctrl.pos_load = 1'b0;
    ctrl.res_sel  = RES_HOLD;
    state_next    = state;
    finish        = 1'b0;
    case (state)
      S_IDLE: begin
        // Head read is always in flight here, so the decision step sees it.
        if (start) begin
          ctrl.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func)
          FUNC_APPEND: begin
            finish = 1'b1;
            if (stat.full) begin
              ctrl.res_sel = RES_REFUSE;
            end else begin
              ctrl.wr_sel  = WR_TAIL;
              ctrl.res_sel = RES_PLAIN;
            end
          end
          FUNC_INSERT: begin
            if (stat.full) begin
              finish       = 1'b1;
              ctrl.res_sel = RES_REFUSE;
            end else if (stat.empty || stat.key_below_head) begin
              finish       = 1'b1;
              ctrl.wr_sel  = WR_FRONT;
              ctrl.res_sel = RES_PLAIN;
            end else if (stat.count_one) begin
              finish       = 1'b1;
              ctrl.wr_sel  = WR_TAIL;
              ctrl.res_sel = RES_PLAIN;
            end else begin
              ctrl.rd_sel = RD_NEXT;
              state_next  = S_SCAN;
            end
          end
          FUNC_REMOVE: begin
            finish       = 1'b1;
            ctrl.res_sel = stat.empty ? RES_PLAIN : RES_POP;
          end
          default: begin
            finish       = 1'b1;
            ctrl.res_sel = RES_PLAIN;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.entry_not_less) begin
          ctrl.pos_load = 1'b1;
          ctrl.rd_sel   = RD_TAIL;
          state_next    = S_SHIFT;
        end else if (stat.scan_last) begin
          finish       = 1'b1;
          ctrl.wr_sel  = WR_TAIL;
          ctrl.res_sel = RES_PLAIN;
        end else begin
          ctrl.rd_sel = RD_NEXT;
        end
      end
      S_SHIFT: begin
        ctrl.wr_sel = WR_SHIFT;
        if (stat.at_pos) begin
          state_next = S_PLACE;
        end else begin
          ctrl.rd_sel = RD_PREV;
        end
      end
      S_PLACE: begin
        finish       = 1'b1;
        ctrl.wr_sel  = WR_POS;
        ctrl.res_sel = RES_PLAIN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      func  <= '0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (ctrl.latch) begin
        func <= func_in;
      end
    end
  end

endmodule

/* hdl/thread_ready_queue_sorted_insert_core.sv */
// Top level of the thread ready queue core: controller plus datapath.
// Depends on trqsi_pkg, trqsi_ctrl, trqsi_dp (and trqsi_ram below it).
//
// A beat on cmd is taken at a rising edge with start high and busy low.
// Every beat yields exactly one result beat on result, shown for a single
// cycle with done high; the receiver cannot stall, so capture it then.
// Entries live in a 16-slot circular RAM with one write and one registered
// read port; that port sets the timing. Append, remove, refusal and the
// unused code finish in the decision step. So does a sorted insert that
// lands at the head or into a queue of one entry. Otherwise it scans
// forward one slot per cycle from the second entry to its slot P, then
// moves the entries from the tail back to P one per cycle and writes the
// new entry at P; an accepted insert meets at most DEPTH - 1 entries. An
// insert whose scan runs off the end lands at the tail. busy stays high
// from accept until the cycle that shows done, and a new beat may be taken
// in that same done cycle. Slot contents need no clearing after reset; only
// entries below the count are ever used.
module thread_ready_queue_sorted_insert_core import trqsi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Sequence the steps of each beat.
  trqsi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .func_in (cmd.func),
    .stat    (stat),
    .ctrl    (ctrl),
    .busy    (busy),
    .done    (done)
  );

  // Hold the slots, head, count and result register.
  trqsi_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result)
  );

endmodule

/* hdl/trqsi_checker.sv */
// Port-level checks for the thread ready queue core, bound to the top level.
// Depends on trqsi_pkg and thread_ready_queue_sorted_insert_core_macros.svh.
`include "thread_ready_queue_sorted_insert_core_macros.svh"

module trqsi_checker import trqsi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  `TRQSI_ASSERT_SAME(a_flags_exclusive, done, !(result.handle_valid && result.insert_refused))
  `TRQSI_ASSERT_SAME(a_empty_matches_count, done, result.queue_empty == (result.entry_count == '0))
  `TRQSI_ASSERT_SAME(a_count_bounded, done, result.entry_count <= COUNT_OUT_W'(DEPTH))
  `TRQSI_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `TRQSI_ASSERT_NEXT(a_single_done, done, !done)

endmodule

bind thread_ready_queue_sorted_insert_core trqsi_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
